// ===== design/vector3_normalize_macros.svh =====
// Assertion macros for the vector3_normalize block.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication under reset
`define VN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize assertion failed");
// next-cycle implication under reset
`define VN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector3_normalize assertion failed");
`else
`define VN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/vn_pkg.sv =====
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int UNIT_W        = 16;
    localparam int LEN_W         = 16;

    localparam int ROOT_W     = IN_WIDTH;
    localparam int SQ_W       = 2 * IN_WIDTH;
    localparam int SUM_W      = 2 * IN_WIDTH;
    localparam int QW         = OUT_FRAC_BITS + 1;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int DIV_CNT_W  = $clog2(QW);

    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(64'd1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] vec_x;
        logic signed [IN_WIDTH-1:0] vec_y;
        logic signed [IN_WIDTH-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic        [LEN_W-1:0]  length;
        logic                     was_zero;
    } t_vec_out;

    typedef struct packed {
        logic load;
        logic div_start;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT_GO,
        S_ROOT,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== design/vn_lane.sv =====
// One component lane: magnitude, square, and restoring divide by the length.
`timescale 1ns / 1ps
module vn_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vn_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [vn_pkg::IN_WIDTH-1:0]  i_comp,
    input  logic        [vn_pkg::ROOT_W-1:0]    i_len,
    output logic        [vn_pkg::SQ_W-1:0]      o_sq,
    output logic                                o_busy,
    output logic signed [vn_pkg::UNIT_W-1:0]    o_unit
);

    localparam int W     = vn_pkg::IN_WIDTH;
    localparam int RW    = vn_pkg::ROOT_W;
    localparam int QW    = vn_pkg::QW;
    localparam int FB    = vn_pkg::OUT_FRAC_BITS;
    localparam int CW    = vn_pkg::DIV_CNT_W;
    localparam int SQ_W  = vn_pkg::SQ_W;

    logic                 r_neg;
    logic [W-1:0]         r_mag;
    logic [SQ_W-1:0]      r_sq;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_dq;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;

    logic [W-1:0]         mag_in;
    logic [RW:0]          rem_sh;
    logic [RW:0]          rem_sub;
    logic                 ge;
    logic signed [QW:0]   q_ext;
    logic signed [QW:0]   q_sgn;

    assign mag_in  = i_comp[W-1] ? W'(-i_comp) : W'(i_comp);
    assign rem_sh  = {r_rem, r_dq[QW-1]};
    assign ge      = rem_sh >= {1'b0, i_len};
    assign rem_sub = rem_sh - {1'b0, i_len};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg <= i_comp[W-1];
            r_mag <= mag_in;
        end
        r_sq <= SQ_W'(r_mag) * SQ_W'(r_mag);
        if (i_ctl.div_start) begin
            r_rem <= RW'(r_mag >> 1);
            r_dq  <= {r_mag[0], {FB{1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
            r_dq  <= {r_dq[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign q_ext  = $signed({1'b0, r_dq});
    assign q_sgn  = r_neg ? -q_ext : q_ext;
    assign o_unit = vn_pkg::UNIT_W'(q_sgn);
    assign o_sq   = r_sq;
    assign o_busy = r_busy;

endmodule

// ===== design/vn_sqrt.sv =====
// Merge stage: sums the lane squares and takes the integer square root, two bits a step.
`timescale 1ns / 1ps
module vn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vn_pkg::SQ_W-1:0]      i_sq_x,
    input  logic [vn_pkg::SQ_W-1:0]      i_sq_y,
    input  logic [vn_pkg::SQ_W-1:0]      i_sq_z,
    output logic                         o_busy,
    output logic [vn_pkg::ROOT_W-1:0]    o_root
);

    localparam int RW    = vn_pkg::ROOT_W;
    localparam int SW    = vn_pkg::SUM_W;
    localparam int CW    = vn_pkg::ROOT_CNT_W;
    localparam int REM_W = RW + 1;
    localparam int SH_W  = RW + 3;

    logic [SW-1:0]    r_rad;
    logic [REM_W-1:0] r_rem;
    logic [RW-1:0]    r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    logic [SH_W-1:0]  rem_sh;
    logic [SH_W-1:0]  trial;
    logic [SH_W-1:0]  rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, r_rad[SW-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= SW'(i_sq_x) + SW'(i_sq_y) + SW'(i_sq_z);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? REM_W'(rem_sub) : REM_W'(rem_sh);
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(RW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== design/vector3_normalize.sv =====
// Top level of the 3D vector normalizer: sequencer, three lanes, root unit, output register.
//
//   channel | direction | valid       | stall        | item
//   in      | input     | i_in_valid  | o_in_stall   | i_in  (vec_x, vec_y, vec_z)
//   out     | output    | o_out_valid | i_out_stall  | o_out (unit_x/y/z, length, was_zero)
//
// Each item passes a square state, 16 root steps in vn_sqrt, then 15 divide steps
// run in all three lanes at once (skipped for a zero vector), plus sequencing.
// One item is in work at a time; a finished item waits in the output register
// while the next one is taken. Reset is synchronous, active low, and empties
// the sequencer and the output register. A stalled output holds the next item
// in the result state until the register frees.
`timescale 1ns / 1ps
`include "vector3_normalize_macros.svh"
module vector3_normalize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vn_pkg::t_vec_in   i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vn_pkg::t_vec_out  o_out
);

    vn_pkg::t_state    r_state;
    vn_pkg::t_state    n_state;
    vn_pkg::t_lane_ctl lane_ctl;
    logic              sqrt_start;
    logic              out_load;

    logic              r_zero;
    logic              r_out_valid;
    vn_pkg::t_vec_out  r_out;
    vn_pkg::t_vec_out  result;

    logic [vn_pkg::SQ_W-1:0]          sq_x, sq_y, sq_z;
    logic                             busy_x, busy_y, busy_z;
    logic signed [vn_pkg::UNIT_W-1:0] unit_x, unit_y, unit_z;
    logic                             sqrt_busy;
    logic [vn_pkg::ROOT_W-1:0]        root;
    logic                             lanes_busy;

    vn_lane u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_comp(i_in.vec_x),
        .i_len(root), .o_sq(sq_x), .o_busy(busy_x), .o_unit(unit_x)
    );
    vn_lane u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_comp(i_in.vec_y),
        .i_len(root), .o_sq(sq_y), .o_busy(busy_y), .o_unit(unit_y)
    );
    vn_lane u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl), .i_comp(i_in.vec_z),
        .i_len(root), .o_sq(sq_z), .o_busy(busy_z), .o_unit(unit_z)
    );

    vn_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_sq_x(sq_x), .i_sq_y(sq_y), .i_sq_z(sq_z),
        .o_busy(sqrt_busy), .o_root(root)
    );

    assign lanes_busy = busy_x | busy_y | busy_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        lane_ctl   = '0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            vn_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    lane_ctl.load = 1'b1;
                    n_state       = vn_pkg::S_SQUARE;
                end
            end
            vn_pkg::S_SQUARE: begin
                n_state = vn_pkg::S_ROOT_GO;
            end
            vn_pkg::S_ROOT_GO: begin
                sqrt_start = 1'b1;
                n_state    = vn_pkg::S_ROOT;
            end
            vn_pkg::S_ROOT: begin
                if (!sqrt_busy) begin
                    n_state = r_zero ? vn_pkg::S_OUT : vn_pkg::S_DIV_GO;
                end
            end
            vn_pkg::S_DIV_GO: begin
                lane_ctl.div_start = 1'b1;
                n_state            = vn_pkg::S_DIV;
            end
            vn_pkg::S_DIV: begin
                if (!lanes_busy) begin
                    n_state = vn_pkg::S_OUT;
                end
            end
            vn_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = vn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vn_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_zero) begin
            result.unit_x   = '0;
            result.unit_y   = '0;
            result.unit_z   = vn_pkg::UNIT_ONE;
            result.length   = '0;
            result.was_zero = 1'b1;
        end else begin
            result.unit_x   = unit_x;
            result.unit_y   = unit_y;
            result.unit_z   = unit_z;
            result.length   = vn_pkg::LEN_W'(root);
            result.was_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctl.load) begin
            r_zero <= (i_in == '0);
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != vn_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `VN_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, o_out_valid && !o_out.was_zero, o_out.length != '0)
    `VN_ASSERT_IMP(a_root_in_state, i_clk, i_rst_n, sqrt_busy, r_state == vn_pkg::S_ROOT)
    `VN_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, lanes_busy, r_state == vn_pkg::S_DIV)
    `VN_ASSERT_NXT(a_div_all_lanes, i_clk, i_rst_n, r_state == vn_pkg::S_DIV_GO, busy_x && busy_y && busy_z)

endmodule
